// File: rtl/bpssq_pkg.sv
// shared types and constants for the barometer pair swap and spike qualifier
package bpssq_pkg;

    localparam int unsigned WORD_W      = 16;
    localparam int unsigned HOLD_W      = 4;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 3;

    localparam logic [HOLD_W-1:0]     SPIKE_HOLD_RESET = HOLD_W'(3);
    localparam logic [WORD_W-1:0]     TALLY_MAX        = '1;
    localparam logic [APB_ADDR_W-1:0] ADDR_SPIKE_HOLD  = APB_ADDR_W'(0);

    typedef struct packed {
        logic [WORD_W-1:0] pressure_raw;
        logic [WORD_W-1:0] temperature_raw;
    } frame_t;

    typedef struct packed {
        logic [WORD_W-1:0] pressure_out;
        logic [WORD_W-1:0] temperature_out;
        logic              baro_valid;
        logic [WORD_W-1:0] sync_error_count;
        logic              spike_active;
    } result_t;

    typedef struct packed {
        logic [WORD_W-1:0] prev_pressure;
        logic [WORD_W-1:0] prev_temperature;
        logic [WORD_W-1:0] good_pressure;
        logic [WORD_W-1:0] good_temperature;
        logic              awaiting_pressure;
        logic [HOLD_W-1:0] hold_countdown;
        logic              valid_flag;
        logic [WORD_W-1:0] error_tally;
    } qual_state_t;

endpackage

// File: rtl/baro_pair_swap_spike_qualifier.sv
// top level: frame input register, qualification step, result register, apb config
// path: a frame is held in the input register, then its result in the result register
// throughput: one frame per cycle unless result_stall holds the result register full
// backpressure: frame_stall rises only when the input register is full and the result
// register is held by result_stall
// reset: rst_n clears all tracking state, empties both stages, spike hold returns to 3
module baro_pair_swap_spike_qualifier
(
    input  logic                              clk,
    input  logic                              rst_n,
    // frame channel
    input  logic                              frame_valid,
    output logic                              frame_stall,
    input  bpssq_pkg::frame_t                 frame,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output bpssq_pkg::result_t                result,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bpssq_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bpssq_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bpssq_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import bpssq_pkg::*;

    // input stage
    logic        stage_valid_reg;
    logic        stage_valid_next;
    frame_t      stage_data_reg;

    // result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_data_reg;

    // tracking state, updated once per frame as it moves to the result stage
    qual_state_t state_reg;
    qual_state_t state_next;
    qual_state_t step_state;
    result_t     step_res;

    logic [HOLD_W-1:0] spike_hold_frames;
    logic              advance;
    logic              frame_take;

    bpssq_cfg u_cfg
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .spike_hold_frames (spike_hold_frames)
    );

    bpssq_step u_step
    (
        .frame_in          (stage_data_reg),
        .cur               (state_reg),
        .spike_hold_frames (spike_hold_frames),
        .nxt               (step_state),
        .res               (step_res)
    );

    // the input stage moves on when the result register is empty or being taken
    assign advance     = stage_valid_reg && (!out_valid_reg || !result_stall);
    // the input register takes a frame when empty or emptying this cycle
    assign frame_stall = stage_valid_reg && !advance;
    assign frame_take  = frame_valid && !frame_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (frame_take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign state_next = advance ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            state_reg       <= state_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            stage_data_reg <= frame;
        end
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // a held pair is never reported as usable
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.spike_active && result.baro_valid))
        else $error("spike hold result flagged valid");

    // the sync error tally only grows
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.error_tally >= $past(state_reg.error_tally))
        else $error("sync error tally decreased");

    // a full input stage that cannot move must stall the frame channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && out_valid_reg && result_stall) |-> frame_stall)
        else $error("input stage overwritten while blocked");

    // each transaction into the result register consumes the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !frame_take) |=> !stage_valid_reg)
        else $error("input stage not released after advance");

endmodule

// File: rtl/bpssq_cfg.sv
// apb register block holding the spike hold length
module bpssq_cfg
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bpssq_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bpssq_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bpssq_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready,
    output logic [bpssq_pkg::HOLD_W-1:0]          spike_hold_frames
);
    import bpssq_pkg::*;

    logic [HOLD_W-1:0] spike_hold_reg;
    logic [HOLD_W-1:0] spike_hold_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_SPIKE_HOLD);

    always_comb
    begin
        spike_hold_next = spike_hold_reg;
        if (wr_en)
        begin
            spike_hold_next = pwdata[HOLD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spike_hold_reg <= SPIKE_HOLD_RESET;
        end
        else
        begin
            spike_hold_reg <= spike_hold_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_SPIKE_HOLD)
        begin
            prdata = {{(APB_DATA_W-HOLD_W){1'b0}}, spike_hold_reg};
        end
    end

    assign spike_hold_frames = spike_hold_reg;

endmodule

// File: rtl/bpssq_step.sv
// per-frame qualification logic: alternation, swap check, spike hold
module bpssq_step
(
    input  bpssq_pkg::frame_t              frame_in,
    input  bpssq_pkg::qual_state_t         cur,
    input  logic [bpssq_pkg::HOLD_W-1:0]   spike_hold_frames,
    output bpssq_pkg::qual_state_t         nxt,
    output bpssq_pkg::result_t             res
);
    import bpssq_pkg::*;

    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] t;
    logic              count_err;
    logic              valid_set;
    logic              swap_hit;
    logic              both_prev;
    logic [WORD_W-1:0] d_pp_p;
    logic [WORD_W-1:0] d_pt_p;
    logic [WORD_W-1:0] d_pt_t;
    logic [WORD_W-1:0] d_pp_t;
    logic [HOLD_W-1:0] hold_load;

    assign p = frame_in.pressure_raw;
    assign t = frame_in.temperature_raw;

    assign d_pp_p = (cur.prev_pressure > p) ? cur.prev_pressure - p : p - cur.prev_pressure;
    assign d_pt_p = (cur.prev_temperature > p) ? cur.prev_temperature - p
                                               : p - cur.prev_temperature;
    assign d_pt_t = (cur.prev_temperature > t) ? cur.prev_temperature - t
                                               : t - cur.prev_temperature;
    assign d_pp_t = (cur.prev_pressure > t) ? cur.prev_pressure - t : t - cur.prev_pressure;

    assign both_prev = (cur.prev_pressure != '0) && (cur.prev_temperature != '0);
    assign swap_hit  = both_prev && ((d_pp_p > d_pt_p) || (d_pt_t > d_pp_t));
    assign hold_load = (p == t) ? spike_hold_frames : cur.hold_countdown;

    always_comb
    begin
        nxt       = cur;
        count_err = 1'b0;
        valid_set = 1'b0;

        // alternation tracking: temperature update then pressure update
        if (!cur.awaiting_pressure)
        begin
            nxt.awaiting_pressure = 1'b1;
            if ((cur.prev_pressure != '0) && (cur.prev_pressure != p))
            begin
                nxt.awaiting_pressure = 1'b0;
                count_err             = 1'b1;
            end
        end
        else
        begin
            nxt.awaiting_pressure = 1'b0;
            if (cur.prev_temperature != '0)
            begin
                if (cur.prev_temperature != t)
                begin
                    nxt.awaiting_pressure = 1'b1;
                    count_err             = 1'b1;
                end
                else
                begin
                    valid_set = 1'b1;
                end
            end
        end

        if (count_err && (cur.error_tally != TALLY_MAX))
        begin
            nxt.error_tally = cur.error_tally + WORD_W'(1);
        end

        nxt.valid_flag = (valid_set || cur.valid_flag) && !swap_hit;

        nxt.prev_pressure    = p;
        nxt.prev_temperature = t;

        res.pressure_out    = p;
        res.temperature_out = t;
        res.spike_active    = 1'b0;

        if (hold_load != '0)
        begin
            nxt.valid_flag      = 1'b0;
            nxt.hold_countdown  = hold_load - HOLD_W'(1);
            res.pressure_out    = cur.good_pressure;
            res.temperature_out = cur.good_temperature;
            res.spike_active    = 1'b1;
        end
        else
        begin
            nxt.hold_countdown   = '0;
            nxt.good_pressure    = p;
            nxt.good_temperature = t;
        end

        res.baro_valid       = nxt.valid_flag;
        res.sync_error_count = nxt.error_tally;
    end

endmodule
